[sv/sdspi_pkg.sv]
// Package with the shared types, codes and tables of the SD card SPI sequencer.
`default_nettype none
package sdspi_pkg;

   // Bytes in one data block.
   localparam int BLOCK_BYTES = 512;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int ADDR_W = BLOCK_SHIFT;
   // Default count of power-up clock bytes.
   localparam int POWERUP_BYTES_DEFAULT = 10;

   // Input item kinds.
   typedef enum logic [2:0] {
      K_INIT  = 3'd0,
      K_READ  = 3'd1,
      K_WRITE = 3'd2,
      K_RX    = 3'd3,
      K_TICK  = 3'd4,
      K_LOAD  = 3'd5
   } kind_type;

   // Result kinds.
   typedef enum logic [1:0] {
      OK_SEND = 2'd0,
      OK_DATA = 2'd1,
      OK_DONE = 2'd2
   } out_kind_type;

   // Done status codes.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_CMD_REJ   = 3'd1,
      ST_TOKEN_TO  = 3'd2,
      ST_WR_REJ    = 3'd3,
      ST_BUSY_TO   = 3'd4,
      ST_INIT_FAIL = 3'd5
   } status_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_READ_TO  = 3'd0,
      CSR_CSD_TO   = 3'd1,
      CSR_WRITE_TO = 3'd2,
      CSR_INIT_TO  = 3'd3,
      CSR_POLL_LIM = 3'd4
   } csr_index_type;

   // Sequencer phases.
   typedef enum logic [4:0] {
      PH_IDLE, PH_POWER, PH_CMD0, PH_CMD8, PH_CMD55, PH_CMD41, PH_CMD58,
      PH_CMD16, PH_CMD9, PH_CMD17, PH_CMD24, PH_CMD8_TAIL, PH_OCR,
      PH_CSD_TOKEN, PH_CSD_DATA, PH_RD_TOKEN, PH_RD_DATA, PH_WR_OUT, PH_WR_BUSY
   } phase_type;

   // Configuration register set.
   typedef struct packed {
      logic [23:0] read_to;
      logic [23:0] csd_to;
      logic [23:0] write_to;
      logic [23:0] init_to;
      logic [3:0]  poll_lim;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  out_byte;
      logic        cs_asserted;
      logic        fast_clock;
      logic [2:0]  status;
      logic [31:0] capacity;
      logic        addressing_by_block;
      logic        last;
   } res_type;

   // Command index byte for a command phase.
   function automatic logic [7:0] cmd_index(input phase_type ph);
      logic [7:0] idx;
      unique case (ph)
         PH_CMD0:  idx = 8'd0;
         PH_CMD8:  idx = 8'd8;
         PH_CMD55: idx = 8'd55;
         PH_CMD41: idx = 8'd41;
         PH_CMD58: idx = 8'd58;
         PH_CMD16: idx = 8'd16;
         PH_CMD9:  idx = 8'd9;
         PH_CMD17: idx = 8'd17;
         PH_CMD24: idx = 8'd24;
         default:  idx = 8'd0;
      endcase
      return idx;
   endfunction

   // CRC byte for a command phase.
   function automatic logic [7:0] cmd_crc(input phase_type ph);
      logic [7:0] crc;
      unique case (ph)
         PH_CMD0:  crc = 8'h95;
         PH_CMD8:  crc = 8'h87;
         PH_CMD55: crc = 8'h65;
         PH_CMD41: crc = 8'h77;
         PH_CMD58: crc = 8'hFD;
         default:  crc = 8'hFF;
      endcase
      return crc;
   endfunction

endpackage
`default_nettype wire

[sv/sdspi_payload_ram.sv]
// Write payload memory with a registered read port and write-to-read bypass.
`default_nettype none
module sdspi_payload_ram
   import sdspi_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [BLOCK_BYTES];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a write in the same cycle to the same entry is passed through.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/sdspi_out_queue.sv]
// Two-entry result queue between the sequencer core and the result channel.
`default_nettype none
module sdspi_out_queue
   import sdspi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic [1:0] push_cnt,
   input  wire res_type  push_res0,
   input  wire res_type  push_res1,
   input  wire logic     pop,
   output logic [1:0]    space,
   output logic          head_valid,
   output res_type       head
);

   res_type    q_ff [2];
   res_type    q_in [2];
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic [1:0] base;

   // Pop shifts the queue; new results go in behind what remains.
   always_comb begin
      base = cnt_ff - {1'b0, pop};
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      case (push_cnt)
         2'd1: q_in[base[0]] = push_res0;
         2'd2: begin
            q_in[0] = push_res0;
            q_in[1] = push_res1;
         end
         default: ;
      endcase
      cnt_in = base + push_cnt;
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign space      = 2'd2 - cnt_ff + {1'b0, pop};
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[0];

endmodule
`default_nettype wire

[sv/sdspi_core.sv]
// Sequencer state and the single-pass logic that turns one transaction into its results.
`default_nettype none
module sdspi_core
   import sdspi_pkg::*;
#(
   parameter int POWERUP_BYTES = POWERUP_BYTES_DEFAULT
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              commit,
   input  wire logic [2:0]        kind,
   input  wire logic [31:0]       lba,
   input  wire logic [7:0]        rx_byte,
   input  wire cfg_type           cfg,
   input  wire logic [7:0]        pay_data,
   output logic [ADDR_W-1:0]      pay_rd_addr,
   output logic [1:0]             res_cnt,
   output res_type                res0,
   output res_type                res1
);

   phase_type   phase_ff, phase_in;
   logic [9:0]  bc_ff, bc_in;
   logic [3:0]  pc_ff, pc_in;
   logic [23:0] wt_ff, wt_in;
   logic [31:0] arg_ff, arg_in;
   logic        bm_ff, bm_in;
   logic        v2_ff, v2_in;
   logic [31:0] ocr_ff, ocr_in;
   logic [23:0] csd_ff, csd_in;
   logic [31:0] cap_ff, cap_in;
   logic        fm_ff, fm_in;
   logic        ir_ff, ir_in;

   logic        send_en, send_cs, fin_en, start_en, data_en, disp_en;
   logic [7:0]  send_b, disp_r;
   status_type  fin_st;
   phase_type   start_ph;
   logic [31:0] start_arg, addr;
   logic [9:0]  bc_inc;
   logic [2:0]  cn;
   logic [3:0]  lim;
   logic [31:0] cap_sum;
   logic [9:0]  bc_next;
   res_type     ev, dv;

   // Next state and results for the transaction in the input register.
   always_comb begin
      phase_in = phase_ff;
      bc_in    = bc_ff;
      pc_in    = pc_ff;
      wt_in    = wt_ff;
      arg_in   = arg_ff;
      bm_in    = bm_ff;
      v2_in    = v2_ff;
      ocr_in   = ocr_ff;
      csd_in   = csd_ff;
      cap_in   = cap_ff;
      fm_in    = fm_ff;
      ir_in    = ir_ff;
      send_en  = 1'b0;
      send_cs  = 1'b1;
      send_b   = 8'hFF;
      fin_en   = 1'b0;
      fin_st   = ST_OK;
      start_en = 1'b0;
      start_ph = PH_IDLE;
      start_arg = 32'd0;
      data_en  = 1'b0;
      disp_en  = 1'b0;
      disp_r   = rx_byte;
      bc_inc   = bc_ff + 10'd1;
      cn       = bc_inc[2:0];
      lim      = (cfg.poll_lim == 4'd0) ? 4'd1 : cfg.poll_lim;
      addr     = bm_ff ? lba : (lba << BLOCK_SHIFT);
      cap_sum  = 32'd0;

      case (kind)
         K_INIT: begin
            if (phase_ff == PH_IDLE) begin
               fm_in    = 1'b0;
               ir_in    = 1'b0;
               phase_in = PH_POWER;
               bc_in    = 10'd0;
               send_en  = 1'b1;
               send_cs  = 1'b0;
            end
         end
         K_READ: begin
            if (phase_ff == PH_IDLE) begin
               ir_in     = 1'b0;
               start_en  = 1'b1;
               start_ph  = PH_CMD17;
               start_arg = addr;
            end
         end
         K_WRITE: begin
            if (phase_ff == PH_IDLE) begin
               start_en  = 1'b1;
               start_ph  = PH_CMD24;
               start_arg = addr;
            end
         end
         K_TICK: begin
            if (wt_ff != 24'd0) begin
               wt_in = wt_ff - 24'd1;
            end
         end
         K_RX: begin
            unique case (phase_ff)
               PH_CMD0, PH_CMD8, PH_CMD55, PH_CMD41, PH_CMD58, PH_CMD16, PH_CMD9,
               PH_CMD17, PH_CMD24: begin
                  // Command frame, then R1 polling.
                  if (bc_ff < 10'd6) begin
                     bc_in   = bc_inc;
                     send_en = 1'b1;
                     case (cn)
                        3'd1: send_b = 8'h40 | cmd_index(phase_ff);
                        3'd2: send_b = arg_ff[31:24];
                        3'd3: send_b = arg_ff[23:16];
                        3'd4: send_b = arg_ff[15:8];
                        3'd5: send_b = arg_ff[7:0];
                        default: send_b = cmd_crc(phase_ff);
                     endcase
                  end else if (bc_ff == 10'd6) begin
                     bc_in   = 10'd7;
                     pc_in   = 4'd1;
                     send_en = 1'b1;
                  end else if (!rx_byte[7]) begin
                     disp_en = 1'b1;
                  end else if (pc_ff >= lim) begin
                     disp_en = 1'b1;
                     disp_r  = 8'hFF;
                  end else begin
                     pc_in   = pc_ff + 4'd1;
                     send_en = 1'b1;
                  end
               end
               PH_POWER: begin
                  bc_in = bc_inc;
                  if (bc_inc < 10'(POWERUP_BYTES)) begin
                     send_en = 1'b1;
                     send_cs = 1'b0;
                  end else begin
                     start_en = 1'b1;
                     start_ph = PH_CMD0;
                  end
               end
               PH_CMD8_TAIL: begin
                  bc_in = bc_inc;
                  if (bc_inc < 10'd4) begin
                     send_en = 1'b1;
                  end else begin
                     wt_in = cfg.init_to;
                     if (cfg.init_to == 24'd0) begin
                        fin_en = 1'b1;
                        fin_st = ST_INIT_FAIL;
                     end else begin
                        start_en = 1'b1;
                        start_ph = PH_CMD55;
                     end
                  end
               end
               PH_OCR: begin
                  ocr_in = {ocr_ff[23:0], rx_byte};
                  bc_in  = bc_inc;
                  if (bc_inc < 10'd4) begin
                     send_en = 1'b1;
                  end else begin
                     bm_in    = ocr_in[30];
                     start_en = 1'b1;
                     if (!ocr_in[30]) begin
                        start_ph  = PH_CMD16;
                        start_arg = 32'(BLOCK_BYTES);
                     end else begin
                        cap_in   = 32'd0;
                        start_ph = PH_CMD9;
                     end
                  end
               end
               PH_CSD_TOKEN: begin
                  if (rx_byte == 8'hFE) begin
                     phase_in = PH_CSD_DATA;
                     bc_in    = 10'd0;
                     send_en  = 1'b1;
                  end else if (wt_ff == 24'd0) begin
                     fm_in    = 1'b1;
                     ir_in    = 1'b1;
                     start_en = 1'b1;
                     start_ph = PH_CMD17;
                  end else begin
                     send_en = 1'b1;
                  end
               end
               PH_CSD_DATA: begin
                  // Pick C_SIZE and the structure bits out of the CSD.
                  case (bc_ff)
                     10'd0: csd_in = {rx_byte[7:6], 22'd0};
                     10'd7: csd_in = csd_ff | {2'd0, rx_byte[5:0], 16'd0};
                     10'd8: csd_in = csd_ff | {8'd0, rx_byte, 8'd0};
                     10'd9: csd_in = csd_ff | {16'd0, rx_byte};
                     default: ;
                  endcase
                  bc_in = bc_inc;
                  if (bc_inc < 10'd18) begin
                     send_en = 1'b1;
                  end else begin
                     if (csd_in[23:22] == 2'd1) begin
                        cap_sum = {10'd0, csd_in[21:0]} + 32'd1;
                        cap_in  = {cap_sum[21:0], 10'd0};
                     end
                     fm_in    = 1'b1;
                     ir_in    = 1'b1;
                     start_en = 1'b1;
                     start_ph = PH_CMD17;
                  end
               end
               PH_RD_TOKEN: begin
                  if (rx_byte == 8'hFE) begin
                     phase_in = PH_RD_DATA;
                     bc_in    = 10'd0;
                     send_en  = 1'b1;
                  end else if (wt_ff == 24'd0) begin
                     fin_en = 1'b1;
                     fin_st = ir_ff ? ST_OK : ST_TOKEN_TO;
                  end else begin
                     send_en = 1'b1;
                  end
               end
               PH_RD_DATA: begin
                  data_en = (bc_ff < 10'(BLOCK_BYTES)) && !ir_ff;
                  bc_in   = bc_inc;
                  if (bc_inc < 10'(BLOCK_BYTES + 2)) begin
                     send_en = 1'b1;
                  end else begin
                     fin_en = 1'b1;
                  end
               end
               PH_WR_OUT: begin
                  if (bc_ff < 10'(BLOCK_BYTES + 4)) begin
                     bc_in   = bc_inc;
                     send_en = 1'b1;
                     if (bc_inc == 10'd1) begin
                        send_b = 8'hFE;
                     end else if (bc_inc < 10'(BLOCK_BYTES + 2)) begin
                        send_b = pay_data;
                     end
                  end else if (rx_byte[4:0] != 5'h05) begin
                     fin_en = 1'b1;
                     fin_st = ST_WR_REJ;
                  end else begin
                     wt_in = cfg.write_to;
                     if (cfg.write_to == 24'd0) begin
                        fin_en = 1'b1;
                        fin_st = ST_BUSY_TO;
                     end else begin
                        phase_in = PH_WR_BUSY;
                        bc_in    = 10'd0;
                        send_en  = 1'b1;
                     end
                  end
               end
               PH_WR_BUSY: begin
                  if (rx_byte != 8'h00) begin
                     fin_en = 1'b1;
                  end else if (wt_ff == 24'd0) begin
                     fin_en = 1'b1;
                     fin_st = ST_BUSY_TO;
                  end else begin
                     send_en = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      // R1 reply handling for the command just framed.
      if (disp_en) begin
         unique case (phase_ff)
            PH_CMD0: begin
               if (disp_r != 8'h01) begin
                  fin_en = 1'b1;
                  fin_st = ST_INIT_FAIL;
               end else begin
                  start_en  = 1'b1;
                  start_ph  = PH_CMD8;
                  start_arg = 32'h1AA;
               end
            end
            PH_CMD8: begin
               v2_in = (disp_r == 8'h01);
               if (disp_r == 8'h01) begin
                  phase_in = PH_CMD8_TAIL;
                  bc_in    = 10'd0;
                  send_en  = 1'b1;
               end else begin
                  wt_in = cfg.init_to;
                  if (cfg.init_to == 24'd0) begin
                     fin_en = 1'b1;
                     fin_st = ST_INIT_FAIL;
                  end else begin
                     start_en = 1'b1;
                     start_ph = PH_CMD55;
                  end
               end
            end
            PH_CMD55: begin
               start_en  = 1'b1;
               start_ph  = PH_CMD41;
               start_arg = v2_ff ? 32'h4000_0000 : 32'd0;
            end
            PH_CMD41: begin
               if (disp_r == 8'h00) begin
                  start_en = 1'b1;
                  start_ph = PH_CMD58;
               end else if (wt_ff == 24'd0) begin
                  fin_en = 1'b1;
                  fin_st = ST_INIT_FAIL;
               end else begin
                  start_en = 1'b1;
                  start_ph = PH_CMD55;
               end
            end
            PH_CMD58: begin
               ocr_in = 32'd0;
               if (disp_r == 8'h00) begin
                  phase_in = PH_OCR;
                  bc_in    = 10'd0;
                  send_en  = 1'b1;
               end else begin
                  bm_in     = 1'b0;
                  start_en  = 1'b1;
                  start_ph  = PH_CMD16;
                  start_arg = 32'(BLOCK_BYTES);
               end
            end
            PH_CMD16: begin
               cap_in   = 32'd0;
               start_en = 1'b1;
               start_ph = PH_CMD9;
            end
            PH_CMD9: begin
               if ((disp_r == 8'h00) && (cfg.csd_to != 24'd0)) begin
                  wt_in    = cfg.csd_to;
                  phase_in = PH_CSD_TOKEN;
                  send_en  = 1'b1;
               end else begin
                  fm_in    = 1'b1;
                  ir_in    = 1'b1;
                  start_en = 1'b1;
                  start_ph = PH_CMD17;
               end
            end
            PH_CMD17: begin
               if (disp_r != 8'h00) begin
                  fin_en = 1'b1;
                  fin_st = ir_ff ? ST_OK : ST_CMD_REJ;
               end else begin
                  wt_in = cfg.read_to;
                  if (cfg.read_to == 24'd0) begin
                     fin_en = 1'b1;
                     fin_st = ir_ff ? ST_OK : ST_TOKEN_TO;
                  end else begin
                     phase_in = PH_RD_TOKEN;
                     bc_in    = 10'd0;
                     send_en  = 1'b1;
                  end
               end
            end
            default: begin
               if (disp_r != 8'h00) begin
                  fin_en = 1'b1;
                  fin_st = ST_CMD_REJ;
               end else begin
                  phase_in = PH_WR_OUT;
                  bc_in    = 10'd0;
                  send_en  = 1'b1;
               end
            end
         endcase
      end

      // Common tails: command start and operation end.
      if (start_en) begin
         phase_in = start_ph;
         arg_in   = start_arg;
         bc_in    = 10'd0;
         pc_in    = 4'd0;
         send_en  = 1'b1;
         send_b   = 8'hFF;
      end
      if (fin_en) begin
         phase_in = PH_IDLE;
         ir_in    = 1'b0;
      end

      // Result assembly.
      ev.out_kind            = fin_en ? OK_DONE : OK_SEND;
      ev.out_byte            = fin_en ? 8'd0 : send_b;
      ev.cs_asserted         = fin_en ? 1'b0 : send_cs;
      ev.fast_clock          = fm_in;
      ev.status              = fin_en ? fin_st : ST_OK;
      ev.capacity            = cap_in;
      ev.addressing_by_block = bm_in;
      ev.last                = 1'b1;
      dv                     = ev;
      dv.out_kind            = OK_DATA;
      dv.out_byte            = rx_byte;
      dv.cs_asserted         = 1'b1;
      dv.status              = ST_OK;
      dv.last                = 1'b0;
      if (data_en) begin
         res0    = dv;
         res1    = ev;
         res_cnt = 2'd2;
      end else begin
         res0    = ev;
         res1    = ev;
         res_cnt = (send_en || fin_en) ? 2'd1 : 2'd0;
      end
   end

   // Payload prefetch: the entry the next write data byte will need.
   always_comb begin
      bc_next     = commit ? bc_in : bc_ff;
      pay_rd_addr = bc_next[ADDR_W-1:0] - ADDR_W'(1);
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bc_ff    <= 10'd0;
         pc_ff    <= 4'd0;
         wt_ff    <= 24'd0;
         arg_ff   <= 32'd0;
         bm_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         ocr_ff   <= 32'd0;
         csd_ff   <= 24'd0;
         cap_ff   <= 32'd0;
         fm_ff    <= 1'b0;
         ir_ff    <= 1'b0;
      end else if (commit) begin
         phase_ff <= phase_in;
         bc_ff    <= bc_in;
         pc_ff    <= pc_in;
         wt_ff    <= wt_in;
         arg_ff   <= arg_in;
         bm_ff    <= bm_in;
         v2_ff    <= v2_in;
         ocr_ff   <= ocr_in;
         csd_ff   <= csd_in;
         cap_ff   <= cap_in;
         fm_ff    <= fm_in;
         ir_ff    <= ir_in;
      end
   end

endmodule
`default_nettype wire

[sv/sd_spi_block_transfer_sequencer.sv]
// Top level of the SD card SPI-mode block transfer sequencer.
// This block sequences SD card SPI-mode init, block read and block write one byte exchange
// at a time: every send result names a byte to shift out, and the byte received for it comes
// back as a received-byte transaction. A transaction is taken into an input register and
// then processed by one pass of logic into a two-entry result queue, so one
// transaction is accepted per clock while the queue has room; a received read data byte yields
// two results and needs both entries free. Write data is loaded into a 512-byte payload memory
// with load transactions and is prefetched one byte ahead during the data phase.
`default_nettype none
module sd_spi_block_transfer_sequencer
   import sdspi_pkg::*;
#(
   parameter int POWERUP_BYTES = POWERUP_BYTES_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [31:0] req_lba,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [8:0]  req_payload_index,
   input  wire logic [7:0]  req_payload_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_cs_asserted,
   output logic             rsp_fast_clock,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_capacity,
   output logic             rsp_addressing_by_block,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   logic        in_valid_ff;
   logic [2:0]  kind_ff;
   logic [31:0] lba_ff;
   logic [7:0]  rx_ff;
   logic [8:0]  pidx_ff;
   logic [7:0]  pbyte_ff;
   cfg_type     cfg_ff;
   logic        fire, pop;
   logic [1:0]  res_cnt, space;
   res_type     res0, res1, head;
   logic [7:0]  pay_data;
   logic [ADDR_W-1:0] pay_rd_addr;

   // Process the registered transaction when its results fit in the queue.
   assign pop       = rsp_valid && rsp_ready;
   assign fire      = in_valid_ff && (res_cnt <= space);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff  <= req_kind;
         lba_ff   <= req_lba;
         rx_ff    <= req_rx_byte;
         pidx_ff  <= req_payload_index;
         pbyte_ff <= req_payload_byte;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_to  <= 24'd500000;
         cfg_ff.csd_to   <= 24'd200000;
         cfg_ff.write_to <= 24'd500000;
         cfg_ff.init_to  <= 24'd2000000;
         cfg_ff.poll_lim <= 4'd10;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_READ_TO:  cfg_ff.read_to  <= csr_data;
            CSR_CSD_TO:   cfg_ff.csd_to   <= csr_data;
            CSR_WRITE_TO: cfg_ff.write_to <= csr_data;
            CSR_INIT_TO:  cfg_ff.init_to  <= csr_data;
            CSR_POLL_LIM: cfg_ff.poll_lim <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   sdspi_payload_ram u_ram (
      .clock   (clock),
      .wr_en   (fire && (kind_ff == K_LOAD)),
      .wr_addr (pidx_ff),
      .wr_data (pbyte_ff),
      .rd_addr (pay_rd_addr),
      .rd_data (pay_data)
   );

   sdspi_core #(
      .POWERUP_BYTES (POWERUP_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .commit      (fire),
      .kind        (kind_ff),
      .lba         (lba_ff),
      .rx_byte     (rx_ff),
      .cfg         (cfg_ff),
      .pay_data    (pay_data),
      .pay_rd_addr (pay_rd_addr),
      .res_cnt     (res_cnt),
      .res0        (res0),
      .res1        (res1)
   );

   sdspi_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (fire ? res_cnt : 2'd0),
      .push_res0  (res0),
      .push_res1  (res1),
      .pop        (pop),
      .space      (space),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_out_kind            = head.out_kind;
   assign rsp_out_byte            = head.out_byte;
   assign rsp_cs_asserted         = head.cs_asserted;
   assign rsp_fast_clock          = head.fast_clock;
   assign rsp_status              = head.status;
   assign rsp_capacity            = head.capacity;
   assign rsp_addressing_by_block = head.addressing_by_block;
   assign rsp_last                = head.last;

endmodule
`default_nettype wire
